[rtl/core/bvm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bvm_pkg: shared types for the byte register VM executor
// Opcode codes and the result record carried by the output stage.
// ----------------------------------------------------------------------------
package bvm_pkg;

  typedef enum logic [7:0] {
    OP_HALT  = 8'd0,
    OP_LOAD  = 8'd1,
    OP_STORE = 8'd2,
    OP_MOVE  = 8'd3,
    OP_PUTI  = 8'd4,
    OP_ADD   = 8'd5,
    OP_SUB   = 8'd6,
    OP_GT    = 8'd7,
    OP_GE    = 8'd8,
    OP_EQ    = 8'd9,
    OP_ITE   = 8'd10,
    OP_JUMP  = 8'd11
  } opcode_e;

  // One executed instruction, as held in the output stage.
  typedef struct packed {
    logic [7:0]  next_pc;
    logic        halted;
    logic        fault;
    logic        wr;
    logic        is_load;   // value comes from the data memory read register
    logic [7:0]  widx;
    logic [31:0] wval;
  } res_t;

endpackage
`default_nettype wire

[rtl/core/byte_register_vm_executor_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_register_vm_executor_top: byte-coded register machine, one op per beat
//
// Input channel: one 32-bit instruction per beat (in_valid_i / in_stall_o).
// Output channel: one result beat per instruction (out_valid_o / out_stall_i)
// carrying the pc after the op, halted and fault flags and the register write.
// The result is registered through the execute stage and then the output stage.
// Throughput: one instruction per cycle when not stalled; the execute stage is
// a single pass through the ALU, compare and one data memory access.
// Pipeline: execute stage (instruction plus registered register-file reads)
// and an output stage. A load reads the data memory at the execute->output
// edge; the register file is written from the output stage and forwarded
// back to the execute stage.
// Reset: pc, halted flag and register-file valid bits clear at once; then a
// clearing pass zeroes the data memory, one byte per cycle over every address,
// with in_stall_o held high. No instruction is taken before it ends.
// Stall: while out_stall_i holds the output beat, the execute stage still
// takes one more instruction, then in_stall_o rises until the output drains.
// Once halted, instructions are consumed without effect and report halted.
// ----------------------------------------------------------------------------
module byte_register_vm_executor_top #(
  parameter int NUM_REGS  = 16,
  parameter int MEM_DEPTH = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // instruction channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] instruction_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       next_pc_o,
  output logic             halted_o,
  output logic             fault_o,
  output logic             reg_written_o,
  output logic [3:0]       written_index_o,
  output logic [31:0]      written_value_o
);

  localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  // --------------------------------------------------------------------------
  // Handshake and pipeline control
  // --------------------------------------------------------------------------
  logic         ex_vld_q, ex_vld_d;
  logic         out_vld_q, out_vld_d;
  logic         ex_adv;      // execute stage moves into the output stage
  logic         in_beat;
  logic         out_beat;
  logic         clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  assign ex_adv     = ex_vld_q & (~out_vld_q | ~out_stall_i);
  assign in_stall_o = clr_busy_q | (ex_vld_q & ~ex_adv);
  assign in_beat    = in_valid_i & ~in_stall_o;
  assign out_beat   = out_vld_q & ~out_stall_i;

  always_comb begin
    ex_vld_d = ex_vld_q;
    if (in_beat) begin
      ex_vld_d = 1'b1;
    end else if (ex_adv) begin
      ex_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (ex_adv) begin
      out_vld_d = 1'b1;
    end else if (out_beat) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      ex_vld_q  <= ex_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // --------------------------------------------------------------------------
  // Data memory clearing pass after reset
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(MEM_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Execute stage registers
  // --------------------------------------------------------------------------
  logic [31:0] ins_q;
  logic [31:0] rd_a_q, rd_b_q, rd_c_q;

  bvm_pkg::res_t out_q;
  logic [7:0]    mem_rdata_q;

  // register file: one copy per read port, written together
  logic [31:0]         rf_a [NUM_REGS];
  logic [31:0]         rf_b [NUM_REGS];
  logic [31:0]         rf_c [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld_q;

  logic          wb_en;
  logic [RW-1:0] wb_addr;
  logic [31:0]   wb_data;

  logic [RW-1:0] in_a, in_b, in_c;

  assign wb_en   = out_vld_q & out_q.wr;
  assign wb_addr = out_q.widx[RW-1:0];
  assign wb_data = out_q.is_load ? {24'd0, mem_rdata_q} : out_q.wval;

  assign in_a = instruction_i[8 +: RW];
  assign in_b = instruction_i[16 +: RW];
  assign in_c = instruction_i[24 +: RW];

  // Write-back repeats each cycle the output stage holds: same value, harmless.
  always_ff @(posedge clk_i) begin
    if (wb_en) begin
      rf_a[wb_addr] <= wb_data;
      rf_b[wb_addr] <= wb_data;
      rf_c[wb_addr] <= wb_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
    end else if (wb_en) begin
      rf_vld_q[wb_addr] <= 1'b1;
    end
  end

  // Registered reads at the input beat, write-first against the write-back.
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      ins_q <= instruction_i;
      if (wb_en && wb_addr == in_a) begin
        rd_a_q <= wb_data;
      end else begin
        rd_a_q <= rf_vld_q[in_a] ? rf_a[in_a] : 32'd0;
      end
      if (wb_en && wb_addr == in_b) begin
        rd_b_q <= wb_data;
      end else begin
        rd_b_q <= rf_vld_q[in_b] ? rf_b[in_b] : 32'd0;
      end
      if (wb_en && wb_addr == in_c) begin
        rd_c_q <= wb_data;
      end else begin
        rd_c_q <= rf_vld_q[in_c] ? rf_c[in_c] : 32'd0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Execute logic
  // --------------------------------------------------------------------------
  logic [7:0]  op, fa, fb, fc;
  logic        a_ok, b_ok, c_ok;
  logic [31:0] ra, rx, ry;
  logic [32:0] diff;
  logic [31:0] sum;
  logic        x_ge, x_eq;
  logic        x_in, a_in;

  logic [7:0]  pc_q, pc_d;
  logic        stopped_q;

  bvm_pkg::res_t ex_res;
  logic          ld_en, st_en;
  logic          halt_c;

  assign op = ins_q[7:0];
  assign fa = ins_q[15:8];
  assign fb = ins_q[23:16];
  assign fc = ins_q[31:24];

  assign a_ok = 32'(fa) < 32'(NUM_REGS);
  assign b_ok = 32'(fb) < 32'(NUM_REGS);
  assign c_ok = 32'(fc) < 32'(NUM_REGS);

  // forward from the output stage, the only write not yet in the read data
  assign ra = (wb_en && out_q.widx == fa) ? wb_data : rd_a_q;
  assign rx = (wb_en && out_q.widx == fb) ? wb_data : rd_b_q;
  assign ry = (wb_en && out_q.widx == fc) ? wb_data : rd_c_q;

  assign sum  = rx + ry;
  assign diff = {1'b0, rx} - {1'b0, ry};
  assign x_ge = ~diff[32];
  assign x_eq = (rx == ry);
  assign x_in = rx < 32'(MEM_DEPTH);
  assign a_in = ra < 32'(MEM_DEPTH);

  always_comb begin
    ex_res         = '0;
    ex_res.next_pc = pc_q + 8'd1;
    ld_en          = 1'b0;
    st_en          = 1'b0;
    halt_c         = 1'b0;
    case (op)
      bvm_pkg::OP_HALT: begin
        halt_c = 1'b1;
      end
      bvm_pkg::OP_LOAD: begin
        if (!a_ok || !b_ok || !x_in) begin
          ex_res.fault = 1'b1;
        end else begin
          ex_res.wr      = 1'b1;
          ex_res.is_load = 1'b1;
          ld_en          = 1'b1;
        end
      end
      bvm_pkg::OP_STORE: begin
        if (!a_ok || !b_ok || !a_in) begin
          ex_res.fault = 1'b1;
        end else begin
          st_en = 1'b1;
        end
      end
      bvm_pkg::OP_MOVE: begin
        if (!a_ok || !b_ok) begin
          ex_res.fault = 1'b1;
        end else begin
          ex_res.wr   = 1'b1;
          ex_res.wval = rx;
        end
      end
      bvm_pkg::OP_PUTI: begin
        if (!a_ok) begin
          ex_res.fault = 1'b1;
        end else begin
          ex_res.wr   = 1'b1;
          ex_res.wval = {24'd0, fb};
        end
      end
      bvm_pkg::OP_ADD, bvm_pkg::OP_SUB, bvm_pkg::OP_GT, bvm_pkg::OP_GE,
      bvm_pkg::OP_EQ: begin
        if (!a_ok || !b_ok || !c_ok) begin
          ex_res.fault = 1'b1;
        end else begin
          ex_res.wr = 1'b1;
          if (op == bvm_pkg::OP_ADD) begin
            ex_res.wval = sum;
          end else if (op == bvm_pkg::OP_SUB) begin
            ex_res.wval = diff[31:0];
          end else if (op == bvm_pkg::OP_GT) begin
            ex_res.wval = {31'd0, x_ge & ~x_eq};
          end else if (op == bvm_pkg::OP_GE) begin
            ex_res.wval = {31'd0, x_ge};
          end else begin
            ex_res.wval = {31'd0, x_eq};
          end
        end
      end
      bvm_pkg::OP_ITE: begin
        if (!a_ok) begin
          ex_res.fault = 1'b1;
        end else begin
          ex_res.next_pc = (ra != 32'd0) ? fb : fc;
        end
      end
      bvm_pkg::OP_JUMP: begin
        ex_res.next_pc = fa;
      end
      default: begin
        ex_res.fault = 1'b1;
      end
    endcase
    ex_res.widx   = ex_res.wr ? fa : 8'd0;
    ex_res.halted = halt_c | ex_res.fault;
    // stopped machine: consume, change nothing
    if (stopped_q) begin
      ex_res         = '0;
      ex_res.next_pc = pc_q;
      ex_res.halted  = 1'b1;
      ld_en          = 1'b0;
      st_en          = 1'b0;
    end
  end

  assign pc_d = ex_adv ? ex_res.next_pc : pc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= 8'd0;
      stopped_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (ex_adv && ex_res.halted) begin
        stopped_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_adv) begin
      out_q <= ex_res;
    end
  end

  // --------------------------------------------------------------------------
  // Data memory: one write port (clear or store), one registered read port
  // --------------------------------------------------------------------------
  logic [7:0]    dmem [MEM_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  assign mem_we    = clr_busy_q | (ex_adv & st_en);
  assign mem_waddr = clr_busy_q ? clr_addr_q : ra[AW-1:0];
  assign mem_wdata = clr_busy_q ? 8'd0 : rx[7:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dmem[mem_waddr] <= mem_wdata;
    end
    if (ex_adv && ld_en) begin
      mem_rdata_q <= dmem[rx[AW-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign out_valid_o     = out_vld_q;
  assign next_pc_o       = out_q.next_pc;
  assign halted_o        = out_q.halted;
  assign fault_o         = out_q.fault;
  assign reg_written_o   = out_q.wr;
  assign written_index_o = out_q.widx[3:0];
  assign written_value_o = wb_data;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_beat_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> in_stall_o)
    else $error("input beat taken during memory clear");

  a_fault_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fault_o) |-> halted_o)
    else $error("fault without halted");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !reg_written_o) |->
      (written_value_o == 32'd0 && written_index_o == 4'd0))
    else $error("write fields nonzero without a register write");

  a_stopped_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |=> stopped_q)
    else $error("machine left the stopped state");

endmodule
`default_nettype wire

[test/byte_register_vm_executor_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_register_vm_executor_top_tb: self-checking bench for the byte VM core
// Runs a directed program, then a long random program of legal instructions,
// ends the program with one stopping event (halt, undefined opcode, bad
// register or memory range) and feeds noise that the stopped machine must
// ignore. A scoreboard models the machine and checks every result beat.
// ----------------------------------------------------------------------------
module byte_register_vm_executor_top_tb;

  localparam int NUM_REGS    = 16;
  localparam int MEM_DEPTH   = 4096;
  localparam int LIVE_ITEMS  = 340;
  localparam int NOISE_ITEMS = 40;
  localparam int CYCLE_LIMIT = 200000;

  // one expected or observed result beat
  typedef struct packed {
    logic [7:0]  next_pc;
    logic        halted;
    logic        fault;
    logic        wr;
    logic [3:0]  widx;
    logic [31:0] wval;
  } vm_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] instruction_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  next_pc_o;
  logic        halted_o;
  logic        fault_o;
  logic        reg_written_o;
  logic [3:0]  written_index_o;
  logic [31:0] written_value_o;

  byte_register_vm_executor_top #(
    .NUM_REGS (NUM_REGS),
    .MEM_DEPTH(MEM_DEPTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .instruction_i  (instruction_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .next_pc_o      (next_pc_o),
    .halted_o       (halted_o),
    .fault_o        (fault_o),
    .reg_written_o  (reg_written_o),
    .written_index_o(written_index_o),
    .written_value_o(written_value_o)
  );

  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Scoreboard: machine state model plus the queue of expected result beats
  // --------------------------------------------------------------------------
  class vm_scoreboard;
    logic [31:0] regs [NUM_REGS];
    logic [7:0]  mem [MEM_DEPTH];
    logic [7:0]  pc;
    bit          stopped;
    vm_result_t  pending[$];
    int unsigned errors;
    int unsigned results_seen;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      pc = '0;
      stopped = 1'b0;
      errors = 0;
      results_seen = 0;
    endfunction

    // execute one accepted instruction on the model, queue its result
    function void note_instr(logic [31:0] ins);
      logic [7:0]  op, a, b, c;
      logic [31:0] x, y;
      vm_result_t  r;
      op = ins[7:0];
      a  = ins[15:8];
      b  = ins[23:16];
      c  = ins[31:24];
      r  = '0;
      if (!stopped) begin
        pc = pc + 8'd1;
        case (op)
          bvm_pkg::OP_HALT: stopped = 1'b1;
          bvm_pkg::OP_LOAD: begin
            if (a >= NUM_REGS || b >= NUM_REGS || regs[b] >= MEM_DEPTH) begin
              r.fault = 1'b1;
            end else begin
              r.wr   = 1'b1;
              r.widx = a[3:0];
              r.wval = {24'd0, mem[regs[b]]};
            end
          end
          bvm_pkg::OP_STORE: begin
            if (a >= NUM_REGS || b >= NUM_REGS || regs[a] >= MEM_DEPTH) r.fault = 1'b1;
            else mem[regs[a]] = regs[b][7:0];
          end
          bvm_pkg::OP_MOVE: begin
            if (a >= NUM_REGS || b >= NUM_REGS) begin
              r.fault = 1'b1;
            end else begin
              r.wr   = 1'b1;
              r.widx = a[3:0];
              r.wval = regs[b];
            end
          end
          bvm_pkg::OP_PUTI: begin
            if (a >= NUM_REGS) begin
              r.fault = 1'b1;
            end else begin
              r.wr   = 1'b1;
              r.widx = a[3:0];
              r.wval = {24'd0, b};
            end
          end
          bvm_pkg::OP_ADD, bvm_pkg::OP_SUB, bvm_pkg::OP_GT, bvm_pkg::OP_GE,
          bvm_pkg::OP_EQ: begin
            if (a >= NUM_REGS || b >= NUM_REGS || c >= NUM_REGS) begin
              r.fault = 1'b1;
            end else begin
              x      = regs[b];
              y      = regs[c];
              r.wr   = 1'b1;
              r.widx = a[3:0];
              case (op)
                bvm_pkg::OP_ADD: r.wval = x + y;
                bvm_pkg::OP_SUB: r.wval = x - y;
                bvm_pkg::OP_GT:  r.wval = {31'd0, x > y};
                bvm_pkg::OP_GE:  r.wval = {31'd0, x >= y};
                default:         r.wval = {31'd0, x == y};
              endcase
            end
          end
          bvm_pkg::OP_ITE: begin
            if (a >= NUM_REGS) r.fault = 1'b1;
            else pc = (regs[a] != 0) ? b : c;
          end
          bvm_pkg::OP_JUMP: pc = a;
          default: r.fault = 1'b1;
        endcase
        if (r.fault) stopped = 1'b1;
        if (r.wr) regs[r.widx] = r.wval;
      end
      r.next_pc = pc;
      r.halted  = stopped;
      pending.push_back(r);
    endfunction

    function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(vm_result_t got);
      vm_result_t exp_r;
      results_seen++;
      if (pending.size() == 0) begin
        $error("result beat with no instruction pending");
        errors++;
      end else begin
        exp_r = pending.pop_front();
        cmp_field("next_pc", 32'(exp_r.next_pc), 32'(got.next_pc));
        cmp_field("halted", 32'(exp_r.halted), 32'(got.halted));
        cmp_field("fault", 32'(exp_r.fault), 32'(got.fault));
        cmp_field("reg_written", 32'(exp_r.wr), 32'(got.wr));
        cmp_field("written_index", 32'(exp_r.widx), 32'(got.widx));
        cmp_field("written_value", exp_r.wval, got.wval);
      end
    endfunction
  endclass

  vm_scoreboard sb;
  int unsigned  sent;
  int unsigned  cycle_count;
  int unsigned  hold_left;
  bit           pressure_done;

  initial sb = new();

  function automatic logic [31:0] vm_word(logic [7:0] op, int a, int b, int c);
    return {c[7:0], b[7:0], a[7:0], op};
  endfunction

  function automatic int rand_reg();
    return $urandom_range(NUM_REGS - 1);
  endfunction

  // register whose value is a legal memory address, -1 when none
  function automatic int find_addr_reg();
    int start;
    int idx;
    start = $urandom_range(NUM_REGS - 1);
    for (int i = 0; i < NUM_REGS; i++) begin
      idx = (start + i) % NUM_REGS;
      if (sb.regs[idx] < MEM_DEPTH) return idx;
    end
    return -1;
  endfunction

  // legal instruction drawn against the current model state
  function automatic logic [31:0] gen_live();
    int pick;
    int idx;
    pick = $urandom_range(99);
    if (pick < 30 && pick >= 18) begin
      idx = find_addr_reg();
      if (idx >= 0) return vm_word(bvm_pkg::OP_LOAD, rand_reg(), idx, $urandom_range(255));
    end else if (pick < 42 && pick >= 30) begin
      idx = find_addr_reg();
      if (idx >= 0) return vm_word(bvm_pkg::OP_STORE, idx, rand_reg(), $urandom_range(255));
    end else if (pick < 50 && pick >= 42) begin
      return vm_word(bvm_pkg::OP_MOVE, rand_reg(), rand_reg(), $urandom_range(255));
    end else if (pick >= 50 && pick < 84) begin
      case ((pick - 50) / 7)
        0:       return vm_word(bvm_pkg::OP_ADD, rand_reg(), rand_reg(), rand_reg());
        1:       return vm_word(bvm_pkg::OP_SUB, rand_reg(), rand_reg(), rand_reg());
        2:       return vm_word(bvm_pkg::OP_GT, rand_reg(), rand_reg(), rand_reg());
        3:       return vm_word(bvm_pkg::OP_GE, rand_reg(), rand_reg(), rand_reg());
        default: return vm_word(bvm_pkg::OP_EQ, rand_reg(), rand_reg(), rand_reg());
      endcase
    end else if (pick >= 84 && pick < 92) begin
      return vm_word(bvm_pkg::OP_ITE, rand_reg(), $urandom_range(255), $urandom_range(255));
    end else if (pick >= 92) begin
      return vm_word(bvm_pkg::OP_JUMP, $urandom_range(255), $urandom_range(255),
                     $urandom_range(255));
    end
    // puti, also the fallback when no register holds a legal address
    return vm_word(bvm_pkg::OP_PUTI, rand_reg(), $urandom_range(255), $urandom_range(255));
  endfunction

  // Offer one instruction beat; called and returns at a falling edge.
  // Valid is only lowered while idling, so back-to-back beats keep it high.
  task automatic send_instr(logic [31:0] ins);
    bit calm;
    calm = (sent >= 180 && sent < 260);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid_i    <= 1'b0;
      instruction_i <= $urandom();
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    instruction_i <= ins;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_instr(ins);
    sent++;
    @(negedge clk_i);
  endtask

  // Finish the program with one event that stops the machine.
  task automatic send_stop();
    int          kind;
    int          op, a, b, c, nfields, f;
    logic [31:0] ins;
    kind = $urandom_range(3);
    case (kind)
      0: ins = vm_word(bvm_pkg::OP_HALT, $urandom_range(255), $urandom_range(255),
                       $urandom_range(255));
      1: ins = vm_word(8'($urandom_range(255, 12)), $urandom_range(255),
                       $urandom_range(255), $urandom_range(255));
      2: begin
        // one used register operand out of range
        op = $urandom_range(bvm_pkg::OP_ITE, bvm_pkg::OP_LOAD);
        a  = rand_reg();
        b  = rand_reg();
        c  = rand_reg();
        if (op >= bvm_pkg::OP_ADD && op <= bvm_pkg::OP_EQ) nfields = 3;
        else if (op == bvm_pkg::OP_PUTI || op == bvm_pkg::OP_ITE) nfields = 1;
        else nfields = 2;
        f = $urandom_range(nfields - 1);
        if (f == 0) a = $urandom_range(255, NUM_REGS);
        else if (f == 1) b = $urandom_range(255, NUM_REGS);
        else c = $urandom_range(255, NUM_REGS);
        ins = vm_word(8'(op), a, b, c);
      end
      default: begin
        // build 255 * 32 in r1, then use it as an address
        send_instr(vm_word(bvm_pkg::OP_PUTI, 1, 255, 0));
        repeat (5) send_instr(vm_word(bvm_pkg::OP_ADD, 1, 1, 1));
        if ($urandom_range(1)) begin
          ins = vm_word(bvm_pkg::OP_STORE, 1, rand_reg(), $urandom_range(255));
        end else begin
          ins = vm_word(bvm_pkg::OP_LOAD, rand_reg(), 1, $urandom_range(255));
        end
      end
    endcase
    send_instr(ins);
  endtask

  // receiver: random stall, one long hold-off, one calm stretch
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_left - 1;
      end else if (!pressure_done && sb.results_seen >= 100) begin
        // long hold-off while the sender keeps offering beats
        pressure_done <= 1'b1;
        hold_left     <= 79;
        out_stall_i   <= 1'b1;
      end else if (sb.results_seen >= 220 && sb.results_seen < 300) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 24);
      end
    end
  end

  always @(posedge clk_i) begin
    vm_result_t got;
    if (out_valid_o && !out_stall_i) begin
      got.next_pc = next_pc_o;
      got.halted  = halted_o;
      got.fault   = fault_o;
      got.wr      = reg_written_o;
      got.widx    = written_index_o;
      got.wval    = written_value_o;
      sb.check_result(got);
    end
  end

  // watchdog; generous against the memory clearing pass plus all stalls
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [31:0] directed [$];
    sent = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed program: memory ends, wrap of add, sub and pc, both ite ways
    directed.push_back(vm_word(bvm_pkg::OP_PUTI, 1, 255, 255));
    directed.push_back(vm_word(bvm_pkg::OP_PUTI, 2, 1, 0));
    directed.push_back(vm_word(bvm_pkg::OP_ADD, 3, 1, 2));
    repeat (4) directed.push_back(vm_word(bvm_pkg::OP_ADD, 3, 3, 3));
    directed.push_back(vm_word(bvm_pkg::OP_SUB, 4, 3, 2));       // top address
    directed.push_back(vm_word(bvm_pkg::OP_STORE, 4, 1, 255));
    directed.push_back(vm_word(bvm_pkg::OP_LOAD, 5, 4, 0));
    directed.push_back(vm_word(bvm_pkg::OP_STORE, 0, 4, 0));     // address zero
    directed.push_back(vm_word(bvm_pkg::OP_LOAD, 15, 0, 255));
    directed.push_back(vm_word(bvm_pkg::OP_SUB, 6, 0, 2));       // wraps to all ones
    directed.push_back(vm_word(bvm_pkg::OP_ADD, 7, 6, 6));       // wraps
    directed.push_back(vm_word(bvm_pkg::OP_GT, 8, 6, 7));
    directed.push_back(vm_word(bvm_pkg::OP_GT, 8, 7, 6));
    directed.push_back(vm_word(bvm_pkg::OP_GE, 9, 7, 7));
    directed.push_back(vm_word(bvm_pkg::OP_EQ, 10, 6, 7));
    directed.push_back(vm_word(bvm_pkg::OP_EQ, 10, 0, 0));
    directed.push_back(vm_word(bvm_pkg::OP_MOVE, 15, 6, 255));
    directed.push_back(vm_word(bvm_pkg::OP_ITE, 1, 200, 7));     // taken
    directed.push_back(vm_word(bvm_pkg::OP_ITE, 0, 9, 255));     // not taken, pc 255
    directed.push_back(vm_word(bvm_pkg::OP_PUTI, 14, 0, 0));     // pc wraps to 0
    directed.push_back(vm_word(bvm_pkg::OP_JUMP, 255, 255, 255));
    directed.push_back(vm_word(bvm_pkg::OP_MOVE, 0, 15, 0));
    foreach (directed[i]) send_instr(directed[i]);

    repeat (LIVE_ITEMS) send_instr(gen_live());
    send_stop();
    // stopped machine: everything below is ignored, any bit pattern goes
    repeat (NOISE_ITEMS) send_instr($urandom());
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/bvm_pkg.sv
rtl/core/byte_register_vm_executor_top.sv
test/byte_register_vm_executor_top_tb.sv
